>>> src/depth_to_color_pixel_registration_macros.svh
// Assertion helpers shared by the registration block.
`ifndef DEPTH_TO_COLOR_PIXEL_REGISTRATION_MACROS_SVH
`define DEPTH_TO_COLOR_PIXEL_REGISTRATION_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define D2C_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define D2C_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/d2c_pkg.sv
package d2c_pkg;

    localparam int FRAME_WIDTH_DEFAULT  = 640;
    localparam int FRAME_HEIGHT_DEFAULT = 480;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_COUNT   = 8;

    // quotient bits of a Q2.30 division: one integer bit, 30 fraction bits
    localparam int DIV_STEPS = 31;

    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_FOCAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_DIST  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_FOCAL = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_DIST  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_K3_LIMIT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_FIRST   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_SECOND  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_LAST    = 3'd7;

    localparam logic [CFG_DATA_W-1:0] K3_LIMIT_RESET = 64'd8589934592000;

    localparam logic signed [31:0] Q30_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q30_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;

    typedef logic signed [31:0] q30_t;
    typedef logic signed [15:0] coef_t;

    typedef struct packed {
        coef_t k1;
        coef_t k2;
        coef_t k3;
        coef_t p1;
        coef_t p2;
    } lens_coef_t;

    function automatic q30_t sat32(input logic signed [63:0] v);
        q30_t r;
        if (v > 64'(Q30_MAX)) begin
            r = Q30_MAX;
        end else if (v < 64'(Q30_MIN)) begin
            r = Q30_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // arithmetic shift right that truncates toward zero
    function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v,
                                                     input int unsigned sh);
        logic signed [63:0] bias;
        logic signed [63:0] r;
        bias = (64'sd1 <<< sh) - 64'sd1;
        if (v < 64'sd0) begin
            r = (v + bias) >>> sh;
        end else begin
            r = v >>> sh;
        end
        return r;
    endfunction

    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat32(trunc_shr(p, 30));
    endfunction

    function automatic q30_t cmul(input coef_t c, input q30_t a);
        logic signed [63:0] p;
        p = 64'(c) * 64'(a);
        return sat32(trunc_shr(p, 14));
    endfunction

endpackage

>>> src/d2c_qdiv.sv
module d2c_qdiv #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 16,
    parameter int SB_W  = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic signed [NUM_W-1:0] num_a,
    input  logic [DEN_W-1:0]        den_a,
    input  logic signed [NUM_W-1:0] num_b,
    input  logic [DEN_W-1:0]        den_b,
    input  logic [SB_W-1:0]         in_sb,
    output logic                    out_valid,
    output d2c_pkg::q30_t           quo_a,
    output d2c_pkg::q30_t           quo_b,
    output logic [SB_W-1:0]         out_sb
);
    import d2c_pkg::*;

    localparam int REM_W = DEN_W + 1;
    localparam int LAST  = DIV_STEPS + 1;

    logic signed [NUM_W-1:0] num_in [0:1];
    logic [DEN_W-1:0]        den_in [0:1];
    logic [NUM_W-1:0]        mag_in [0:1];

    logic [REM_W-1:0]     rem_reg [0:1][0:DIV_STEPS];
    logic [DEN_W-1:0]     den_reg [0:1][0:DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_reg [0:1][0:DIV_STEPS];
    logic                 neg_reg [0:1][0:DIV_STEPS];
    logic                 sat_reg [0:1][0:DIV_STEPS];
    q30_t                 res_reg [0:1];

    logic [LAST:0]   vld_reg;
    logic [SB_W-1:0] sb_reg [0:LAST];

    always_comb begin
        num_in[0] = num_a;
        num_in[1] = num_b;
        den_in[0] = den_a;
        den_in[1] = den_b;
        for (int l = 0; l < 2; l++) begin
            mag_in[l] = num_in[l][NUM_W-1] ? NUM_W'(-num_in[l]) : NUM_W'(num_in[l]);
        end
    end

    genvar l, s;
    for (l = 0; l < 2; l++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[l][0] <= REM_W'(mag_in[l]);
                den_reg[l][0] <= den_in[l];
                quo_reg[l][0] <= '0;
                neg_reg[l][0] <= num_in[l][NUM_W-1];
                // quotient would not fit Q2.30
                sat_reg[l][0] <= ({1'b0, mag_in[l]} >= {den_in[l], 1'b0});
            end
        end

        for (s = 1; s <= DIV_STEPS; s++) begin : g_step
            logic [REM_W-1:0] trial;
            logic             ge;
            always_comb begin
                if (s == 1) begin
                    trial = rem_reg[l][s-1];
                end else begin
                    trial = {rem_reg[l][s-1][REM_W-2:0], 1'b0};
                end
                ge = (trial >= {1'b0, den_reg[l][s-1]});
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[l][s] <= ge ? trial - {1'b0, den_reg[l][s-1]} : trial;
                    den_reg[l][s] <= den_reg[l][s-1];
                    quo_reg[l][s] <= {quo_reg[l][s-1][DIV_STEPS-2:0], ge};
                    neg_reg[l][s] <= neg_reg[l][s-1];
                    sat_reg[l][s] <= sat_reg[l][s-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                if (sat_reg[l][DIV_STEPS]) begin
                    res_reg[l] <= neg_reg[l][DIV_STEPS] ? Q30_MIN : Q30_MAX;
                end else if (neg_reg[l][DIV_STEPS]) begin
                    res_reg[l] <= -$signed({1'b0, quo_reg[l][DIV_STEPS]});
                end else begin
                    res_reg[l] <= $signed({1'b0, quo_reg[l][DIV_STEPS]});
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sb_reg[0] <= in_sb;
            for (int i = 1; i <= LAST; i++) begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[LAST];
    assign out_sb    = sb_reg[LAST];
    assign quo_a     = res_reg[0];
    assign quo_b     = res_reg[1];

endmodule

>>> src/d2c_lens.sv
module d2c_lens #(
    parameter int SB_W        = 1,
    parameter bit APPLY_FIRST = 1'b0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  d2c_pkg::q30_t         in_x,
    input  d2c_pkg::q30_t         in_y,
    input  d2c_pkg::lens_coef_t   coef,
    input  logic [SB_W-1:0]       in_sb,
    output logic                  out_valid,
    output d2c_pkg::q30_t         out_ux,
    output d2c_pkg::q30_t         out_uy,
    output logic [SB_W-1:0]       out_sb
);
    import d2c_pkg::*;

    localparam int STAGES = 11;

    logic [STAGES-1:0] vld_reg;
    logic [SB_W-1:0]   sb_reg [0:STAGES-1];

    q30_t x_reg [0:6];
    q30_t y_reg [0:6];
    q30_t r2_reg [1:7];
    q30_t xx0_reg, yy0_reg;
    q30_t r4_reg, r6_reg, f_reg;
    q30_t kr1_reg [2:4];
    q30_t kr2_reg [3:4];
    q30_t kr3_reg;
    q30_t gx_reg [6:9];
    q30_t gy_reg [6:9];
    q30_t xy7_reg, xx7_reg, yy7_reg;
    q30_t sx_reg, sy_reg;
    logic signed [32:0] t2x_reg [8:9];
    logic signed [32:0] t2y_reg [8:9];
    q30_t t3x_reg, t3y_reg;
    q30_t ux_reg, uy_reg;

    q30_t ax, ay;

    // color side distorts radially first and forms the tangential terms from that
    always_comb begin
        ax = APPLY_FIRST ? gx_reg[6] : x_reg[6];
        ay = APPLY_FIRST ? gy_reg[6] : y_reg[6];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sb_reg[0] <= in_sb;
            for (int i = 1; i < STAGES; i++) begin
                sb_reg[i] <= sb_reg[i-1];
            end

            x_reg[0] <= in_x;
            y_reg[0] <= in_y;
            for (int i = 1; i <= 6; i++) begin
                x_reg[i] <= x_reg[i-1];
                y_reg[i] <= y_reg[i-1];
            end
            for (int i = 2; i <= 7; i++) begin
                r2_reg[i] <= r2_reg[i-1];
            end

            xx0_reg <= mul30(in_x, in_x);
            yy0_reg <= mul30(in_y, in_y);

            r2_reg[1] <= sat32(64'(xx0_reg) + 64'(yy0_reg));

            r4_reg     <= mul30(r2_reg[1], r2_reg[1]);
            kr1_reg[2] <= cmul(coef.k1, r2_reg[1]);

            r6_reg     <= mul30(r4_reg, r2_reg[2]);
            kr2_reg[3] <= cmul(coef.k2, r4_reg);
            kr1_reg[3] <= kr1_reg[2];

            kr3_reg    <= cmul(coef.k3, r6_reg);
            kr2_reg[4] <= kr2_reg[3];
            kr1_reg[4] <= kr1_reg[3];

            f_reg <= sat32(Q30_ONE + 64'(kr1_reg[4]) + 64'(kr2_reg[4]) + 64'(kr3_reg));

            gx_reg[6] <= mul30(x_reg[5], f_reg);
            gy_reg[6] <= mul30(y_reg[5], f_reg);
            for (int i = 7; i <= 9; i++) begin
                gx_reg[i] <= gx_reg[i-1];
                gy_reg[i] <= gy_reg[i-1];
            end

            xy7_reg <= mul30(ax, ay);
            xx7_reg <= mul30(ax, ax);
            yy7_reg <= mul30(ay, ay);

            sx_reg     <= sat32(64'(r2_reg[7]) + (64'(xx7_reg) <<< 1));
            sy_reg     <= sat32(64'(r2_reg[7]) + (64'(yy7_reg) <<< 1));
            t2x_reg[8] <= $signed({cmul(coef.p1, xy7_reg), 1'b0});
            t2y_reg[8] <= $signed({cmul(coef.p2, xy7_reg), 1'b0});

            t3x_reg    <= cmul(coef.p2, sx_reg);
            t3y_reg    <= cmul(coef.p1, sy_reg);
            t2x_reg[9] <= t2x_reg[8];
            t2y_reg[9] <= t2y_reg[8];

            ux_reg <= sat32(64'(gx_reg[9]) + 64'(t2x_reg[9]) + 64'(t3x_reg));
            uy_reg <= sat32(64'(gy_reg[9]) + 64'(t2y_reg[9]) + 64'(t3y_reg));
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_sb    = sb_reg[STAGES-1];
    assign out_ux    = ux_reg;
    assign out_uy    = uy_reg;

endmodule

>>> src/depth_to_color_pixel_registration.sv
// One item per cycle while the result is not stalled.
// Two restoring dividers with 31 quotient stages each (one bit per stage) set most of the depth;
// one lens stage holds a multiply bank beside a wide add.
// A stalled result freezes the whole pipeline; a free output slot lets it advance.
// Synchronous active-low reset clears valid bits and loads register reset values.
module depth_to_color_pixel_registration #(
    parameter int FRAME_WIDTH  = d2c_pkg::FRAME_WIDTH_DEFAULT,
    parameter int FRAME_HEIGHT = d2c_pkg::FRAME_HEIGHT_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [d2c_pkg::CFG_INDEX_W-1:0]  cfg_wr_index,
    input  logic [d2c_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [9:0]                       s_pixel_col,
    input  logic [8:0]                       s_pixel_row,
    input  logic [15:0]                      s_depth_raw,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [9:0]                       m_target_col,
    output logic [8:0]                       m_target_row,
    output logic [15:0]                      m_write_value
);
    import d2c_pkg::*;

    localparam int SB1_W = 33;
    localparam int SB2_W = 17;

    logic [CFG_DATA_W-1:0] cfg_reg [0:CFG_COUNT-1];

    logic [CFG_DATA_W-1:0] dfc, ddist, cfc, cdist, k3l, rf, rs, rl;
    logic [15:0] d_fx, d_fy, d_ppx, d_ppy, c_fx, c_fy, c_ppx, c_ppy, limit;
    lens_coef_t depth_coef, color_coef;
    coef_t rot [0:8];
    coef_t trn [0:2];

    logic pipe_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                cfg_reg[i] <= (i == int'(REG_K3_LIMIT)) ? K3_LIMIT_RESET : '0;
            end
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_wr_index] <= cfg_wr_data;
        end
    end

    always_comb begin
        dfc   = cfg_reg[REG_DEPTH_FOCAL];
        ddist = cfg_reg[REG_DEPTH_DIST];
        cfc   = cfg_reg[REG_COLOR_FOCAL];
        cdist = cfg_reg[REG_COLOR_DIST];
        k3l   = cfg_reg[REG_K3_LIMIT];
        rf    = cfg_reg[REG_ROT_FIRST];
        rs    = cfg_reg[REG_ROT_SECOND];
        rl    = cfg_reg[REG_ROT_LAST];

        d_fx  = dfc[15:0];
        d_fy  = dfc[31:16];
        d_ppx = dfc[47:32];
        d_ppy = dfc[63:48];
        c_fx  = cfc[15:0];
        c_fy  = cfc[31:16];
        c_ppx = cfc[47:32];
        c_ppy = cfc[63:48];
        limit = k3l[47:32];

        depth_coef.k1 = ddist[15:0];
        depth_coef.k2 = ddist[31:16];
        depth_coef.p1 = ddist[47:32];
        depth_coef.p2 = ddist[63:48];
        depth_coef.k3 = k3l[15:0];
        color_coef.k1 = cdist[15:0];
        color_coef.k2 = cdist[31:16];
        color_coef.p1 = cdist[47:32];
        color_coef.p2 = cdist[63:48];
        color_coef.k3 = k3l[31:16];

        for (int i = 0; i < 4; i++) begin
            rot[i]     = rf[16*i +: 16];
            rot[4 + i] = rs[16*i +: 16];
        end
        rot[8] = rl[15:0];
        trn[0] = rl[31:16];
        trn[1] = rl[47:32];
        trn[2] = rl[63:48];
    end

    // ---------------- entry stage ----------------
    logic                   in_vld_reg;
    logic signed [17:0]     nx_reg, ny_reg;
    logic [SB1_W-1:0]       sb0_reg;
    logic [15:0]            wval_next;
    logic                   nofocal_next;

    always_comb begin
        wval_next    = (s_depth_raw < limit) ? s_depth_raw : 16'd0;
        nofocal_next = (d_fx == 16'd0) || (d_fy == 16'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (pipe_adv) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            nx_reg  <= $signed({4'b0, s_pixel_col, 4'b0}) - $signed({2'b0, d_ppx});
            ny_reg  <= $signed({5'b0, s_pixel_row, 4'b0}) - $signed({2'b0, d_ppy});
            sb0_reg <= {s_depth_raw, wval_next, nofocal_next};
        end
    end

    // ---------------- deprojection ----------------
    logic             div1_vld;
    q30_t             div1_x, div1_y;
    logic [SB1_W-1:0] div1_sb;

    d2c_qdiv #(.NUM_W(18), .DEN_W(16), .SB_W(SB1_W)) u_div_depth (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (pipe_adv),
        .in_valid  (in_vld_reg),
        .num_a     (nx_reg),
        .den_a     (d_fx),
        .num_b     (ny_reg),
        .den_b     (d_fy),
        .in_sb     (sb0_reg),
        .out_valid (div1_vld),
        .quo_a     (div1_x),
        .quo_b     (div1_y),
        .out_sb    (div1_sb)
    );

    logic             lens_d_valid;
    q30_t             ux, uy;
    logic [SB1_W-1:0] lens_d_sb;

    d2c_lens #(.SB_W(SB1_W), .APPLY_FIRST(1'b0)) u_lens_depth (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (pipe_adv),
        .in_valid  (div1_vld),
        .in_x      (div1_x),
        .in_y      (div1_y),
        .coef      (depth_coef),
        .in_sb     (div1_sb),
        .out_valid (lens_d_valid),
        .out_ux    (ux),
        .out_uy    (uy),
        .out_sb    (lens_d_sb)
    );

    // ---------------- point and rigid transform ----------------
    logic               p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic signed [33:0] p0_reg, p1_reg;
    logic [15:0]        dep1_reg;
    logic [SB2_W-1:0]   sb1_reg, sb2_reg, sb3_reg;
    logic signed [50:0] mq_reg [0:2][0:2];
    logic signed [39:0] q_reg [0:2];

    logic signed [63:0] p0_full, p1_full;
    logic signed [63:0] mq_full [0:2][0:2];
    logic signed [63:0] acc_full [0:2];
    logic signed [63:0] q_full [0:2];

    always_comb begin
        p0_full = trunc_shr(64'($signed({1'b0, lens_d_sb[32:17]})) * 64'(ux), 14);
        p1_full = trunc_shr(64'($signed({1'b0, lens_d_sb[32:17]})) * 64'(uy), 14);
        for (int i = 0; i < 3; i++) begin
            mq_full[i][0] = 64'(rot[i]) * 64'(p0_reg);
            mq_full[i][1] = 64'(rot[3 + i]) * 64'(p1_reg);
            mq_full[i][2] = (64'(rot[6 + i]) * 64'($signed({1'b0, dep1_reg}))) <<< 16;
            acc_full[i]   = 64'(mq_reg[i][0]) + 64'(mq_reg[i][1]) + 64'(mq_reg[i][2]);
            q_full[i]     = trunc_shr(acc_full[i], 14) + (64'(trn[i]) <<< 16);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end else if (pipe_adv) begin
            p1_vld_reg <= lens_d_valid;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            p0_reg   <= p0_full[33:0];
            p1_reg   <= p1_full[33:0];
            dep1_reg <= lens_d_sb[32:17];
            sb1_reg  <= lens_d_sb[16:0];

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    mq_reg[i][j] <= mq_full[i][j][50:0];
                end
            end
            sb2_reg  <= sb1_reg;

            for (int i = 0; i < 3; i++) begin
                q_reg[i] <= q_full[i][39:0];
            end
            // point at or behind the color camera lands at the origin
            sb3_reg <= {sb2_reg[16:1], sb2_reg[0] || (q_full[2] <= 64'sd0)};
        end
    end

    // ---------------- projection ----------------
    logic             div2_vld;
    q30_t             div2_x, div2_y;
    logic [SB2_W-1:0] div2_sb;

    d2c_qdiv #(.NUM_W(40), .DEN_W(39), .SB_W(SB2_W)) u_div_color (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (pipe_adv),
        .in_valid  (p3_vld_reg),
        .num_a     (q_reg[0]),
        .den_a     (q_reg[2][38:0]),
        .num_b     (q_reg[1]),
        .den_b     (q_reg[2][38:0]),
        .in_sb     (sb3_reg),
        .out_valid (div2_vld),
        .quo_a     (div2_x),
        .quo_b     (div2_y),
        .out_sb    (div2_sb)
    );

    logic             lens_c_valid;
    q30_t             dx, dy;
    logic [SB2_W-1:0] lens_c_sb;

    d2c_lens #(.SB_W(SB2_W), .APPLY_FIRST(1'b1)) u_lens_color (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (pipe_adv),
        .in_valid  (div2_vld),
        .in_x      (div2_x),
        .in_y      (div2_y),
        .coef      (color_coef),
        .in_sb     (div2_sb),
        .out_valid (lens_c_valid),
        .out_ux    (dx),
        .out_uy    (dy),
        .out_sb    (lens_c_sb)
    );

    // ---------------- pixel mapping ----------------
    logic               x1_vld_reg;
    logic signed [49:0] pc_reg, pr_reg;
    logic [SB2_W-1:0]   sb4_reg;
    logic               m_valid_reg;
    logic [9:0]         col_reg;
    logic [8:0]         row_reg;
    logic [15:0]        wval_reg;

    logic signed [63:0] pc_full, pr_full, vc, vr;
    logic [9:0]         col_next;
    logic [8:0]         row_next;

    always_comb begin
        pc_full = 64'(dx) * 64'($signed({1'b0, c_fx}));
        pr_full = 64'(dy) * 64'($signed({1'b0, c_fy}));
        vc = trunc_shr(64'(pc_reg) + (64'($signed({1'b0, c_ppx})) <<< 30), 34);
        vr = trunc_shr(64'(pr_reg) + (64'($signed({1'b0, c_ppy})) <<< 30), 34);
        if (vc < 64'sd0) begin
            vc = 64'sd0;
        end else if (vc > 64'(FRAME_WIDTH) - 64'sd1) begin
            vc = 64'(FRAME_WIDTH) - 64'sd1;
        end
        if (vr < 64'sd0) begin
            vr = 64'sd0;
        end else if (vr > 64'(FRAME_HEIGHT) - 64'sd1) begin
            vr = 64'(FRAME_HEIGHT) - 64'sd1;
        end
        col_next = sb4_reg[0] ? 10'd0 : vc[9:0];
        row_next = sb4_reg[0] ? 9'd0 : vr[8:0];
    end

    assign pipe_adv = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (pipe_adv) begin
            x1_vld_reg  <= lens_c_valid;
            m_valid_reg <= x1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            pc_reg   <= pc_full[49:0];
            pr_reg   <= pr_full[49:0];
            sb4_reg  <= lens_c_sb;
            col_reg  <= col_next;
            row_reg  <= row_next;
            wval_reg <= sb4_reg[16:1];
        end
    end

    assign s_ready       = pipe_adv;
    assign m_valid       = m_valid_reg;
    assign m_target_col  = col_reg;
    assign m_target_row  = row_reg;
    assign m_write_value = wval_reg;

`include "depth_to_color_pixel_registration_macros.svh"

    `D2C_ASSERT_IMP(a_col_in_frame, m_valid, (FRAME_WIDTH > 1024) || ({22'b0, m_target_col} <= 32'(FRAME_WIDTH - 1)), "target column past frame")
    `D2C_ASSERT_IMP(a_row_in_frame, m_valid, (FRAME_HEIGHT > 512) || ({23'b0, m_target_row} <= 32'(FRAME_HEIGHT - 1)), "target row past frame")
    `D2C_ASSERT_NXT(a_stall_freezes, !pipe_adv, $stable(lens_d_valid) && $stable(div2_vld) && $stable(x1_vld_reg), "pipeline moved during stall")

endmodule
